// ===== src/rrq_pkg.sv =====
// shared constants, codes and types of the reservation release queue
`default_nettype none

package rrq_pkg;

    localparam int NUM_BUSES   = 8;
    localparam int CES_PER_BUS = 8;
    localparam int QUEUE_DEPTH = 64;

    localparam int NUM_CES   = NUM_BUSES * CES_PER_BUS;
    localparam int BUS_IDX_W = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;
    localparam int CE_IDX_W  = (NUM_CES > 1) ? $clog2(NUM_CES) : 1;

    localparam int TYPE_W  = 2;
    localparam int ID_W    = 3;
    localparam int DUR_W   = 20;
    localparam int TIME_W  = 48;
    localparam int REL_W   = 49;
    localparam int UTIL_W  = 64;
    localparam int STAT_W  = 3;

    // request modes
    localparam logic MODE_RESERVE = 1'b0;
    localparam logic MODE_POP     = 1'b1;

    // resource types
    localparam logic [TYPE_W-1:0] RT_DMA_DOWN = 2'd0;
    localparam logic [TYPE_W-1:0] RT_DMA_UP   = 2'd1;
    localparam logic [TYPE_W-1:0] RT_CE       = 2'd2;
    localparam logic [TYPE_W-1:0] RT_INVALID  = 2'd3;

    // response status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_BUSY    = 3'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd4;

    typedef struct packed {
        logic [TYPE_W-1:0] res_type;
        logic [ID_W-1:0]   bus;
        logic [ID_W-1:0]   ce;
        logic [REL_W-1:0]  rel;
    } rrq_entry_t;

    // operation broadcast to every cell of the queue
    typedef struct packed {
        logic       ins;
        logic       pop;
        rrq_entry_t new_entry;
    } rrq_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/rrq_if.sv =====
// request and response channel interfaces
`default_nettype none

interface rrq_req_if
    import rrq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [TYPE_W-1:0] res_type;
    logic [ID_W-1:0]   bus_id;
    logic [ID_W-1:0]   ce_id;
    logic [DUR_W-1:0]  duration;
    logic [TIME_W-1:0] now_us;
    logic              paired;

    modport source (
        output valid, mode, res_type, bus_id, ce_id, duration, now_us, paired,
        input  ready
    );
    modport sink (
        input  valid, mode, res_type, bus_id, ce_id, duration, now_us, paired,
        output ready
    );
endinterface

interface rrq_rsp_if
    import rrq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [TYPE_W-1:0] out_type;
    logic [ID_W-1:0]   out_bus;
    logic [ID_W-1:0]   out_ce;
    logic [REL_W-1:0]  release_time;
    logic [UTIL_W-1:0] bus_util_total;
    logic [UTIL_W-1:0] ce_util_total;

    modport source (
        output valid, status, out_type, out_bus, out_ce, release_time,
               bus_util_total, ce_util_total,
        input  ready
    );
    modport sink (
        input  valid, status, out_type, out_bus, out_ce, release_time,
               bus_util_total, ce_util_total,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/rrq_cell.sv =====
// one slot of the sorted shift-register queue
`default_nettype none

module rrq_cell
    import rrq_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rrq_cell_ctrl_t ctrl,
    input  wire rrq_entry_t     left_entry,
    input  wire logic           left_valid,
    input  wire logic           left_keep,
    input  wire rrq_entry_t     right_entry,
    input  wire logic           right_valid,
    output rrq_entry_t          entry,
    output logic                valid,
    output logic                keep
);

    rrq_entry_t entry_reg, entry_next;
    logic       valid_reg, valid_next;

    // entry stays put on insert when it releases no later than the new one
    assign keep  = valid_reg && (entry_reg.rel <= ctrl.new_entry.rel);
    assign entry = entry_reg;
    assign valid = valid_reg;

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.ins && !keep)
        begin
            if (left_keep)
            begin
                entry_next = ctrl.new_entry;
                valid_next = 1'b1;
            end
            else
            begin
                entry_next = left_entry;
                valid_next = left_valid;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ===== src/resource_reservation_release_queue.sv =====
// top level: busy tracking, utilization totals and sorted release queue
//
// Tracks a busy flag per flash bus (shared by dma down and dma up) and per
// chip enable, and keeps up to QUEUE_DEPTH reservations ordered by release
// time (now_us + duration) in a chain of cells, earliest at the head. A
// reserve request is checked for type/range (invalid), then busy, then queue
// full; an accepted one marks its resource busy, adds duration (doubled when
// paired) to the bus or chip enable utilization total and is placed behind
// all entries with equal or earlier release time. A pop removes the head,
// frees its resource and returns it, or reports empty. Every request gives
// exactly one response carrying both running totals. Each transaction has
// a capture step, which registers the request and forms its release time,
// and an execute step, in which every cell compares against the new entry
// in parallel and the whole chain shifts at once. A new request is taken
// while the previous response still waits in the output register; the
// execute step holds until that register is free.
`default_nettype none

module resource_reservation_release_queue
    import rrq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rrq_req_if.sink   req,
    rrq_rsp_if.source rsp
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // captured request
    logic              mode_reg;
    logic [TYPE_W-1:0] type_reg;
    logic [ID_W-1:0]   bus_reg;
    logic [ID_W-1:0]   ce_reg;
    logic [DUR_W-1:0]  dur_reg;
    logic [REL_W-1:0]  rel_reg;
    logic              paired_reg;

    // resource state
    logic [NUM_BUSES-1:0] bus_busy_reg, bus_busy_next;
    logic [NUM_CES-1:0]   ce_busy_reg, ce_busy_next;
    logic [UTIL_W-1:0]    bus_util_reg, bus_util_next;
    logic [UTIL_W-1:0]    ce_util_reg, ce_util_next;

    // response register
    logic              rsp_valid_reg;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [TYPE_W-1:0] out_type_reg, out_type_next;
    logic [ID_W-1:0]   out_bus_reg, out_bus_next;
    logic [ID_W-1:0]   out_ce_reg, out_ce_next;
    logic [REL_W-1:0]  out_rel_reg, out_rel_next;

    // cell chain
    rrq_cell_ctrl_t cell_ctrl;
    rrq_entry_t     cell_entry [QUEUE_DEPTH];
    logic           cell_valid [QUEUE_DEPTH];
    logic           cell_keep  [QUEUE_DEPTH];

    // decode of the captured request
    logic                 req_take;
    logic                 exec_go;
    logic                 is_bus;
    logic                 bad_req;
    logic                 res_busy;
    logic                 queue_full;
    logic                 ins_ok;
    logic                 pop_ok;
    logic [BUS_IDX_W-1:0] bus_idx;
    logic [CE_IDX_W-1:0]  ce_idx;
    logic [BUS_IDX_W-1:0] head_bus_idx;
    logic [CE_IDX_W-1:0]  head_ce_idx;
    logic [DUR_W:0]       util_add;
    rrq_entry_t           head;

    assign req.ready = (state_reg == S_IDLE);
    assign req_take  = req.valid && req.ready;
    // execute only when the response slot is free or being emptied
    assign exec_go   = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);

    assign is_bus  = (type_reg == RT_DMA_DOWN) || (type_reg == RT_DMA_UP);
    assign bad_req = (type_reg == RT_INVALID) || (int'(bus_reg) >= NUM_BUSES) ||
                     (!is_bus && (int'(ce_reg) >= CES_PER_BUS));
    assign bus_idx = BUS_IDX_W'(bus_reg);
    assign ce_idx  = CE_IDX_W'(int'(bus_reg) * CES_PER_BUS + int'(ce_reg));

    assign res_busy   = is_bus ? bus_busy_reg[bus_idx] : ce_busy_reg[ce_idx];
    assign queue_full = cell_valid[QUEUE_DEPTH-1];
    assign ins_ok     = (mode_reg == MODE_RESERVE) && !bad_req && !res_busy &&
                        !queue_full;
    assign pop_ok     = (mode_reg == MODE_POP) && cell_valid[0];

    assign util_add = paired_reg ? {dur_reg, 1'b0} : {1'b0, dur_reg};

    assign head         = cell_entry[0];
    assign head_bus_idx = BUS_IDX_W'(head.bus);
    assign head_ce_idx  = CE_IDX_W'(int'(head.bus) * CES_PER_BUS + int'(head.ce));

    // broadcast operation to the chain
    always_comb
    begin
        cell_ctrl.ins                = exec_go && ins_ok;
        cell_ctrl.pop                = exec_go && pop_ok;
        cell_ctrl.new_entry.res_type = type_reg;
        cell_ctrl.new_entry.bus      = bus_reg;
        cell_ctrl.new_entry.ce       = ce_reg;
        cell_ctrl.new_entry.rel      = rel_reg;
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        rrq_entry_t left_entry, right_entry;
        logic       left_valid, left_keep, right_valid;

        if (i == 0)
        begin : g_head
            // head takes the new entry whenever it does not keep its own
            assign left_entry = '0;
            assign left_valid = 1'b0;
            assign left_keep  = 1'b1;
        end
        else
        begin : g_body
            assign left_entry = cell_entry[i-1];
            assign left_valid = cell_valid[i-1];
            assign left_keep  = cell_keep[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_entry = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[i+1];
            assign right_valid = cell_valid[i+1];
        end

        rrq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .left_entry  (left_entry),
            .left_valid  (left_valid),
            .left_keep   (left_keep),
            .right_entry (right_entry),
            .right_valid (right_valid),
            .entry       (cell_entry[i]),
            .valid       (cell_valid[i]),
            .keep        (cell_keep[i])
        );
    end

    // state, busy flags, totals and response contents
    always_comb
    begin
        state_next    = state_reg;
        bus_busy_next = bus_busy_reg;
        ce_busy_next  = ce_busy_reg;
        bus_util_next = bus_util_reg;
        ce_util_next  = ce_util_reg;
        status_next   = status_reg;
        out_type_next = out_type_reg;
        out_bus_next  = out_bus_reg;
        out_ce_next   = out_ce_reg;
        out_rel_next  = out_rel_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next    = S_IDLE;
                    status_next   = ST_OK;
                    out_type_next = '0;
                    out_bus_next  = '0;
                    out_ce_next   = '0;
                    out_rel_next  = '0;
                    if (mode_reg == MODE_POP)
                    begin
                        if (!cell_valid[0])
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            out_type_next = head.res_type;
                            out_bus_next  = head.bus;
                            out_ce_next   = head.ce;
                            out_rel_next  = head.rel;
                            if ((head.res_type == RT_DMA_DOWN) ||
                                (head.res_type == RT_DMA_UP))
                            begin
                                if (int'(head.bus) < NUM_BUSES)
                                begin
                                    bus_busy_next[head_bus_idx] = 1'b0;
                                end
                            end
                            else if ((int'(head.bus) < NUM_BUSES) &&
                                     (int'(head.ce) < CES_PER_BUS))
                            begin
                                ce_busy_next[head_ce_idx] = 1'b0;
                            end
                        end
                    end
                    else if (bad_req)
                    begin
                        status_next = ST_INVALID;
                    end
                    else if (res_busy)
                    begin
                        status_next = ST_BUSY;
                    end
                    else if (queue_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        out_type_next = type_reg;
                        out_bus_next  = bus_reg;
                        out_ce_next   = ce_reg;
                        out_rel_next  = rel_reg;
                        if (is_bus)
                        begin
                            bus_busy_next[bus_idx] = 1'b1;
                            bus_util_next = bus_util_reg + UTIL_W'(util_add);
                        end
                        else
                        begin
                            ce_busy_next[ce_idx] = 1'b1;
                            ce_util_next = ce_util_reg + UTIL_W'(util_add);
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bus_busy_reg  <= '0;
            ce_busy_reg   <= '0;
            bus_util_reg  <= '0;
            ce_util_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bus_busy_reg <= bus_busy_next;
            ce_busy_reg  <= ce_busy_next;
            bus_util_reg <= bus_util_next;
            ce_util_reg  <= ce_util_next;
            if (exec_go)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // request capture and response payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            mode_reg   <= req.mode;
            type_reg   <= req.res_type;
            bus_reg    <= req.bus_id;
            ce_reg     <= req.ce_id;
            dur_reg    <= req.duration;
            paired_reg <= req.paired;
            rel_reg    <= {1'b0, req.now_us} + REL_W'(req.duration);
        end
        status_reg   <= status_next;
        out_type_reg <= out_type_next;
        out_bus_reg  <= out_bus_next;
        out_ce_reg   <= out_ce_next;
        out_rel_reg  <= out_rel_next;
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.out_type       = out_type_reg;
    assign rsp.out_bus        = out_bus_reg;
    assign rsp.out_ce         = out_ce_reg;
    assign rsp.release_time   = out_rel_reg;
    // totals are only touched in the execute cycle that loads the response
    assign rsp.bus_util_total = bus_util_reg;
    assign rsp.ce_util_total  = ce_util_reg;

endmodule

`default_nettype wire

// ===== dv/rrq_release_checker.sv =====
// response checker for the reservation release queue: watches both channels and predicts
`timescale 1ns / 100ps

module rrq_release_checker
    import rrq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rrq_req_if   req,
    rrq_rsp_if   rsp,
    output int   mismatch_count,
    output int   outstanding,
    output int   checked_count,
    output int   full_count
);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TYPE_W-1:0] out_type;
        logic [ID_W-1:0]   out_bus;
        logic [ID_W-1:0]   out_ce;
        logic [REL_W-1:0]  release_time;
        logic [UTIL_W-1:0] bus_util_total;
        logic [UTIL_W-1:0] ce_util_total;
    } rrq_response_t;

    // shadow state of the block
    logic [NUM_BUSES-1:0] bus_held;
    logic [NUM_CES-1:0]   ce_held;
    rrq_entry_t           release_order[$];
    logic [UTIL_W-1:0]    bus_busy_us;
    logic [UTIL_W-1:0]    ce_busy_us;

    rrq_response_t        expected_responses[$];

    function automatic string describe(input rrq_response_t r);
        return $sformatf("status %0d type %0d bus %0d ce %0d rel %0h bus_util %0h ce_util %0h",
                         r.status, r.out_type, r.out_bus, r.out_ce, r.release_time,
                         r.bus_util_total, r.ce_util_total);
    endfunction

    function automatic rrq_response_t predict_reservation_response(
        input logic              mode,
        input logic [TYPE_W-1:0] res_type,
        input logic [ID_W-1:0]   bus_id,
        input logic [ID_W-1:0]   ce_id,
        input logic [DUR_W-1:0]  duration,
        input logic [TIME_W-1:0] now_us,
        input logic              paired
    );
        rrq_response_t     r;
        rrq_entry_t        e;
        logic              is_bus;
        int                ce_idx;
        int                pos;
        logic [UTIL_W-1:0] add;

        r = '0;
        if (mode == MODE_POP)
        begin
            if (release_order.size() == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                e = release_order[0];
                release_order.delete(0);
                if (e.res_type == RT_DMA_DOWN || e.res_type == RT_DMA_UP)
                    bus_held[e.bus] = 1'b0;
                else
                    ce_held[int'(e.bus) * CES_PER_BUS + int'(e.ce)] = 1'b0;
                r.status       = ST_OK;
                r.out_type     = e.res_type;
                r.out_bus      = e.bus;
                r.out_ce       = e.ce;
                r.release_time = e.rel;
            end
        end
        else
        begin
            is_bus = (res_type == RT_DMA_DOWN || res_type == RT_DMA_UP);
            ce_idx = int'(bus_id) * CES_PER_BUS + int'(ce_id);
            if (res_type == RT_INVALID || int'(bus_id) >= NUM_BUSES ||
                (!is_bus && int'(ce_id) >= CES_PER_BUS))
            begin
                r.status = ST_INVALID;
            end
            else if (is_bus ? bus_held[bus_id] : ce_held[ce_idx])
            begin
                r.status = ST_BUSY;
            end
            else if (release_order.size() >= QUEUE_DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                add = UTIL_W'(duration);
                if (paired)
                    add = add << 1;
                if (is_bus)
                begin
                    bus_held[bus_id] = 1'b1;
                    bus_busy_us      = bus_busy_us + add;
                end
                else
                begin
                    ce_held[ce_idx] = 1'b1;
                    ce_busy_us      = ce_busy_us + add;
                end
                e.res_type = res_type;
                e.bus      = bus_id;
                e.ce       = ce_id;
                e.rel      = REL_W'(now_us) + REL_W'(duration);
                // new entry goes behind all equal or earlier release times
                pos = 0;
                while (pos < release_order.size() && release_order[pos].rel <= e.rel)
                    pos++;
                release_order.insert(pos, e);
                r.status       = ST_OK;
                r.out_type     = e.res_type;
                r.out_bus      = e.bus;
                r.out_ce       = e.ce;
                r.release_time = e.rel;
            end
        end
        r.bus_util_total = bus_busy_us;
        r.ce_util_total  = ce_busy_us;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rrq_response_t got;
        rrq_response_t exp;

        if (!rst_n)
        begin
            bus_held    = '0;
            ce_held     = '0;
            bus_busy_us = '0;
            ce_busy_us  = '0;
            release_order.delete();
            expected_responses.delete();
            mismatch_count = 0;
            outstanding    = 0;
            checked_count  = 0;
            full_count     = 0;
        end
        else
        begin
            // response side first: it can never belong to a request taken at this edge
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                got.status         = rsp.status;
                got.out_type       = rsp.out_type;
                got.out_bus        = rsp.out_bus;
                got.out_ce         = rsp.out_ce;
                got.release_time   = rsp.release_time;
                got.bus_util_total = rsp.bus_util_total;
                got.ce_util_total  = rsp.ce_util_total;
                if (expected_responses.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("[%0t] unexpected response: %s", $realtime, describe(got));
                    mismatch_count++;
                end
                else
                begin
                    exp = expected_responses[0];
                    expected_responses.delete(0);
                    checked_count++;
                    if (exp.status == ST_FULL)
                        full_count++;
                    if (got.status !== exp.status || got.out_type !== exp.out_type ||
                        got.out_bus !== exp.out_bus || got.out_ce !== exp.out_ce ||
                        got.release_time !== exp.release_time ||
                        got.bus_util_total !== exp.bus_util_total ||
                        got.ce_util_total !== exp.ce_util_total)
                    begin
                        if (mismatch_count < 10)
                            $display("[%0t] mismatch\n  expected %s\n  actual   %s",
                                     $realtime, describe(exp), describe(got));
                        mismatch_count++;
                    end
                end
            end
            if (req.valid === 1'b1 && req.ready === 1'b1)
                expected_responses.push_back(predict_reservation_response(
                    req.mode, req.res_type, req.bus_id, req.ce_id,
                    req.duration, req.now_us, req.paired));
            outstanding = expected_responses.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// stimulus, receiver stalls, watchdog and verdict for the reservation release queue
`timescale 1ns / 100ps

module tb_top;
    import rrq_pkg::*;

    // cycles without any accepted transaction before the run is abandoned;
    // far above the longest sender gap plus the longest receiver stall
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 1950;

    typedef struct packed {
        logic              mode;
        logic [TYPE_W-1:0] res_type;
        logic [ID_W-1:0]   bus_id;
        logic [ID_W-1:0]   ce_id;
        logic [DUR_W-1:0]  duration;
        logic [TIME_W-1:0] now_us;
        logic              paired;
    } rrq_request_t;

    logic clk;
    logic rst_n;

    rrq_req_if req_ch ();
    rrq_rsp_if rsp_ch ();

    int mismatch_count;
    int outstanding;
    int checked_count;
    int full_count;

    // request counters for the closing summary
    int n_reserve;
    int n_pop;
    int n_random;

    // sender pacing: bursts of random length, gaps up to gap_limit
    int burst_left;
    int gap_limit;

    resource_reservation_release_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rrq_release_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .checked_count  (checked_count),
        .full_count     (full_count)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // receiver: response ready follows a randomly drawn style that is redrawn
    // whenever its run ends (always ready, coin flip, mostly stalled, fixed mask)
    // ------------------------------------------------------------------
    int         stall_style;
    int         style_left = 0;
    int         mask_phase = 0;
    logic [7:0] ready_mask;

    always @(negedge clk)
    begin
        logic ready_bit;

        if (style_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(64, 256);
            ready_mask  = 8'($urandom_range(1, 255));
        end
        else
        begin
            style_left--;
        end
        mask_phase = (mask_phase + 1) % 8;
        case (stall_style)
            0:       ready_bit = 1'b1;
            1:       ready_bit = 1'($urandom_range(0, 1));
            2:       ready_bit = ($urandom_range(0, 3) == 0);
            default: ready_bit = ready_mask[mask_phase];
        endcase
        rsp_ch.ready <= ready_bit;
    end

    // ------------------------------------------------------------------
    // watchdog: counts cycles in which no transaction moves on either side
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d responses pending",
                         idle_cycles, outstanding);
                $display("resource_reservation_release_queue regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // request building
    // ------------------------------------------------------------------
    function automatic rrq_request_t make_item(input logic m, input logic [TYPE_W-1:0] t,
                                               input int b, input int c,
                                               input logic [DUR_W-1:0] d,
                                               input logic [TIME_W-1:0] now,
                                               input logic p);
        rrq_request_t item;

        item.mode     = m;
        item.res_type = t;
        item.bus_id   = ID_W'(b);
        item.ce_id    = ID_W'(c);
        item.duration = d;
        item.now_us   = now;
        item.paired   = p;
        return item;
    endfunction

    // mostly small times so release times collide, plus full range and top end
    function automatic logic [TIME_W-1:0] random_time();
        logic [31:0] hi;
        logic [31:0] lo;

        hi = $urandom;
        lo = $urandom;
        case ($urandom_range(0, 3))
            0:       return {hi[15:0], lo};
            3:       return {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 3));
            default: return TIME_W'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [DUR_W-1:0] random_duration();
        case ($urandom_range(0, 3))
            0:       return DUR_W'($urandom);
            3:       return {DUR_W{1'b1}} - DUR_W'($urandom_range(0, 1));
            default: return DUR_W'($urandom_range(0, 15));
        endcase
    endfunction

    // well-formed traffic: valid types most of the time, ids optionally
    // squeezed onto a couple of resources so busy rejects show up
    function automatic rrq_request_t random_request(input int pop_pct, input bit focused);
        logic [TYPE_W-1:0] t;
        int                r;

        r = $urandom_range(0, 19);
        if (r == 0)
            t = RT_INVALID;
        else if (r < 7)
            t = $urandom_range(0, 1) ? RT_DMA_UP : RT_DMA_DOWN;
        else
            t = RT_CE;
        return make_item(($urandom_range(0, 99) < pop_pct) ? MODE_POP : MODE_RESERVE, t,
                         focused ? $urandom_range(0, 1) : $urandom_range(0, 7),
                         focused ? $urandom_range(0, 1) : $urandom_range(0, 7),
                         random_duration(), random_time(), 1'($urandom_range(0, 1)));
    endfunction

    // ------------------------------------------------------------------
    // request driving: fields change at the falling edge, valid stays up
    // between back-to-back transactions
    // ------------------------------------------------------------------
    task automatic drive_request(input rrq_request_t item);
        @(negedge clk);
        req_ch.valid    <= 1'b1;
        req_ch.mode     <= item.mode;
        req_ch.res_type <= item.res_type;
        req_ch.bus_id   <= item.bus_id;
        req_ch.ce_id    <= item.ce_id;
        req_ch.duration <= item.duration;
        req_ch.now_us   <= item.now_us;
        req_ch.paired   <= item.paired;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        if (item.mode == MODE_POP)
            n_pop++;
        else
            n_reserve++;
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // hold the sender until the block has answered everything taken so far
    task automatic pause_until_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait (outstanding == 0);
    endtask

    task automatic send_paced(input rrq_request_t item);
        int gap;

        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_limit);
            if (gap > 0)
                idle_sender(gap);
            burst_left = $urandom_range(1, 16);
        end
        drive_request(item);
        burst_left--;
        n_random++;
    endtask

    // empty the queue with surplus pops, then reserve every bus and chip
    // enable in shuffled order: the first QUEUE_DEPTH go in, the rest hit full
    task automatic fill_to_capacity();
        rrq_request_t pool[NUM_BUSES + NUM_CES];
        rrq_request_t tmp;
        int           j;

        pause_until_drained();
        for (int k = 0; k < QUEUE_DEPTH + 6; k++)
            send_paced(random_request(100, 1'b0));
        for (int b = 0; b < NUM_BUSES; b++)
            pool[b] = make_item(MODE_RESERVE, $urandom_range(0, 1) ? RT_DMA_UP : RT_DMA_DOWN,
                                b, $urandom_range(0, 7), random_duration(), random_time(),
                                1'($urandom_range(0, 1)));
        for (int c = 0; c < NUM_CES; c++)
            pool[NUM_BUSES + c] = make_item(MODE_RESERVE, RT_CE, c / CES_PER_BUS,
                                            c % CES_PER_BUS, random_duration(),
                                            random_time(), 1'($urandom_range(0, 1)));
        for (int i = NUM_BUSES + NUM_CES - 1; i > 0; i--)
        begin
            j       = $urandom_range(0, i);
            tmp     = pool[i];
            pool[i] = pool[j];
            pool[j] = tmp;
        end
        foreach (pool[i])
            send_paced(pool[i]);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int           phase;
        int           len;
        int           pop_pct;
        bit           focused;
        rrq_request_t item;

        clk             = 1'b0;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.mode     = MODE_RESERVE;
        req_ch.res_type = RT_DMA_DOWN;
        req_ch.bus_id   = '0;
        req_ch.ce_id    = '0;
        req_ch.duration = '0;
        req_ch.now_us   = '0;
        req_ch.paired   = 1'b0;
        rsp_ch.ready    = 1'b0;
        n_reserve       = 0;
        n_pop           = 0;
        n_random        = 0;
        burst_left      = 0;
        gap_limit       = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty pop, invalid type, shared dma flag, ce busy,
        // top-end times that carry into bit 48, tied release times, pops to empty
        drive_request(make_item(MODE_POP, RT_DMA_DOWN, 0, 0, '0, '0, 1'b0));
        drive_request(make_item(MODE_RESERVE, RT_INVALID, 7, 7, '1, '1, 1'b1));
        drive_request(make_item(MODE_RESERVE, RT_DMA_DOWN, 0, 0, '0, '0, 1'b0));
        drive_request(make_item(MODE_RESERVE, RT_DMA_UP, 0, 3, 20'd9, 48'd9, 1'b0));
        drive_request(make_item(MODE_RESERVE, RT_DMA_UP, 7, 0, '1, '1, 1'b1));
        drive_request(make_item(MODE_RESERVE, RT_CE, 7, 7, '1, '1, 1'b1));
        drive_request(make_item(MODE_RESERVE, RT_CE, 7, 7, 20'd1, 48'd1, 1'b0));
        drive_request(make_item(MODE_RESERVE, RT_CE, 0, 0, 20'd0, 48'd5, 1'b0));
        drive_request(make_item(MODE_RESERVE, RT_CE, 0, 1, 20'd2, 48'd3, 1'b1));
        drive_request(make_item(MODE_RESERVE, RT_DMA_DOWN, 3, 5, 20'd1, 48'd0, 1'b0));
        drive_request(make_item(MODE_RESERVE, RT_CE, 3, 0, 20'd1, 48'd0, 1'b1));
        repeat (8)
            drive_request(make_item(MODE_POP, RT_DMA_DOWN, 0, 0, '0, '0, 1'b0));
        drive_request(make_item(MODE_POP, RT_INVALID, 7, 7, '1, '1, 1'b1));

        // make sure the sender waits out the block at least once
        pause_until_drained();

        // random phases: churn of reserves and pops, full-queue fills, raw noise
        while (n_random < RANDOM_ITEMS)
        begin
            phase = $urandom_range(0, 9);
            case ($urandom_range(0, 2))
                0:       gap_limit = 0;
                1:       gap_limit = 3;
                default: gap_limit = 12;
            endcase
            burst_left = 0;
            if (phase == 0)
            begin
                fill_to_capacity();
            end
            else if (phase <= 7)
            begin
                len     = $urandom_range(40, 120);
                pop_pct = $urandom_range(20, 60);
                focused = 1'($urandom_range(0, 1));
                repeat (len)
                    send_paced(random_request(pop_pct, focused));
            end
            else
            begin
                len = $urandom_range(20, 60);
                repeat (len)
                begin
                    item = make_item(1'($urandom_range(0, 1)), TYPE_W'($urandom_range(0, 3)),
                                     $urandom_range(0, 7), $urandom_range(0, 7),
                                     DUR_W'($urandom), {16'($urandom), 32'($urandom)},
                                     1'($urandom_range(0, 1)));
                    send_paced(item);
                end
            end
            if ($urandom_range(0, 4) == 0)
                pause_until_drained();
        end

        // drain, then let the capture and execute pipeline settle
        pause_until_drained();
        repeat (8) @(posedge clk);

        $display("covered %0d requests (%0d reserves, %0d pops), %0d responses checked",
                 n_reserve + n_pop, n_reserve, n_pop, checked_count);
        $display("queue driven to capacity with %0d full rejects, %0d mismatches",
                 full_count, mismatch_count);
        if (mismatch_count == 0)
            $display("resource_reservation_release_queue regression: pass");
        else
            $display("resource_reservation_release_queue regression: fail");
        $finish;
    end

endmodule
